FILE: hw/rtl/agke_pkg.sv
package agke_pkg;

    localparam int unsigned SUM_W   = 40;
    localparam int unsigned OUT_W   = 24;
    localparam int unsigned SCALE_W = 16;
    localparam int unsigned RW_W    = 16;
    localparam int unsigned GATE_W  = 16;
    localparam int unsigned DIM_W   = 6;
    localparam int unsigned P_W     = 32;
    localparam int unsigned R_W     = 28;
    localparam int unsigned M_W     = 33;
    localparam int unsigned K_W     = 3;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [P_W-1:0]   Q31_ONE = 32'h8000_0000;
    localparam logic [K_W-1:0]   K_FIRST = 3'd6;

    localparam logic [1:0] REG_SCALE = 2'd0;
    localparam logic [1:0] REG_GWID  = 2'd1;
    localparam logic [1:0] REG_ARD   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_WM,
        ST_ACC,
        ST_EINIT,
        ST_EMUL,
        ST_EDIV,
        ST_ECOR,
        ST_ESQ,
        ST_EOUT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [RW_W-1:0]    gwidth;
        logic               ard;
    } t_cfg;

    typedef struct packed {
        logic accept_elem;
        logic load_tab;
        logic calc_sq;
        logic calc_wm;
        logic accumulate;
        logic exp_init;
        logic exp_mul;
        logic exp_div;
        logic exp_cor;
        logic exp_sq;
        logic exp_out;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic in_is_elem;
        logic last;
        logic exp_skip;
        logic k_last;
        logic sq_last;
        logic out_free;
    } t_status;

    function automatic logic [M_W-1:0] recip_of(input logic [K_W-1:0] k);
        logic [M_W-1:0] m;
        unique case (k)
            3'd1:    m = 33'h1_0000_0000;
            3'd2:    m = 33'h0_8000_0000;
            3'd3:    m = 33'd1431655765;
            3'd4:    m = 33'h0_4000_0000;
            3'd5:    m = 33'd858993459;
            3'd6:    m = 33'd715827882;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: hw/rtl/agke_ctrl.sv
module agke_ctrl
    import agke_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.in_is_elem) n_state = ST_SQ;
            end
            ST_SQ:    n_state = ST_WM;
            ST_WM:    n_state = ST_ACC;
            ST_ACC:   n_state = i_status.last ? ST_EINIT : ST_IDLE;
            ST_EINIT: n_state = i_status.exp_skip ? ST_EOUT : ST_EMUL;
            ST_EMUL:  n_state = ST_EDIV;
            ST_EDIV:  n_state = ST_ECOR;
            ST_ECOR:  n_state = i_status.k_last ? ST_ESQ : ST_EMUL;
            ST_ESQ: begin
                if (i_status.sq_last) n_state = ST_EOUT;
            end
            ST_EOUT:  n_state = ST_FIN;
            ST_FIN: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall        = 1'b0;
                o_cmd.accept_elem = i_in_valid && i_status.in_is_elem;
                o_cmd.load_tab    = i_in_valid && !i_status.in_is_elem;
            end
            ST_SQ:    o_cmd.calc_sq    = 1'b1;
            ST_WM:    o_cmd.calc_wm    = 1'b1;
            ST_ACC:   o_cmd.accumulate = 1'b1;
            ST_EINIT: o_cmd.exp_init   = 1'b1;
            ST_EMUL:  o_cmd.exp_mul    = 1'b1;
            ST_EDIV:  o_cmd.exp_div    = 1'b1;
            ST_ECOR:  o_cmd.exp_cor    = 1'b1;
            ST_ESQ:   o_cmd.exp_sq     = 1'b1;
            ST_EOUT:  o_cmd.exp_out    = 1'b1;
            ST_FIN:   o_cmd.finish     = i_status.out_free;
            default:  o_cmd            = '0;
        endcase
    end

endmodule

FILE: hw/rtl/agke_datapath.sv
module agke_datapath
    import agke_pkg::*;
#(
    parameter int unsigned MAX_DIMS     = 64,
    parameter int unsigned FEATURE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  t_cmd                    i_cmd_ctl,
    output t_status                 o_status,
    input  logic                    i_cmd,
    input  logic [DIM_W-1:0]        i_dim_index,
    input  logic [RW_W-1:0]         i_recip_width_in,
    input  logic [FEATURE_BITS-1:0] i_feature_a,
    input  logic [FEATURE_BITS-1:0] i_feature_b,
    input  logic                    i_elem_valid,
    input  logic                    i_last,
    input  logic [GATE_W-1:0]       i_gating,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic [OUT_W-1:0]        o_kernel_value,
    output logic                    o_saturated
);

    localparam int unsigned IDX_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_DIMS + 1);
    localparam int unsigned AD_W   = FEATURE_BITS + 1;
    localparam int unsigned SQ_W   = 2 * AD_W;
    localparam int unsigned LO_W   = 45;
    localparam int unsigned SQX_W  = (SQ_W > LO_W) ? SQ_W : LO_W + 1;
    localparam int unsigned PRD_W  = LO_W + RW_W;
    localparam int unsigned TERM_W = PRD_W - 4;
    localparam int unsigned CMP_W  = 11;

    logic [RW_W-1:0] mem [MAX_DIMS];
    logic [RW_W-1:0] r_rd;

    logic [AD_W-1:0]   r_ad;
    logic              r_valid;
    logic              r_last;
    logic [GATE_W-1:0] r_gate;
    logic [SQX_W-1:0]  r_sq;
    logic [RW_W-1:0]   r_w;
    logic [PRD_W-1:0]  r_prod;
    logic              r_big;

    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;
    logic             r_sat;

    logic [R_W-1:0]           r_r;
    logic [P_W-1:0]           r_p;
    logic [R_W-1:0]           r_x;
    logic [R_W+M_W-1:0]       r_qm;
    logic [K_W-1:0]           r_k;
    logic [K_W-1:0]           r_sqcnt;
    logic [SCALE_W+GATE_W-1:0] r_sgp;
    logic [2*P_W-1:0]         r_fin;

    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_val;
    logic                r_out_sat;

    logic signed [AD_W-1:0] diff;
    logic [AD_W-1:0]        ad;
    logic                   use_w;
    logic [TERM_W-1:0]      term;
    logic [TERM_W-1:0]      room;
    logic                   acc_sat;
    logic [R_W-1:0]         q_est;
    logic [R_W+K_W-1:0]     qk;
    logic [R_W-1:0]         rem;
    logic [R_W-1:0]         q_fix;
    logic [2*P_W-1:0]       rp;
    logic [2*P_W-1:0]       pp;
    logic [2*P_W-39:0]      val;
    logic                   val_big;

    assign diff = $signed({i_feature_a[FEATURE_BITS-1], i_feature_a})
                - $signed({i_feature_b[FEATURE_BITS-1], i_feature_b});
    assign ad   = diff[AD_W-1] ? AD_W'(-diff) : AD_W'(diff);

    assign use_w   = !(i_cfg.ard && (r_count >= CNT_W'(MAX_DIMS)));
    assign term    = TERM_W'(r_prod >> 4);
    assign room    = TERM_W'(SUM_MAX - r_sum);
    assign acc_sat = r_big || (term > room);

    assign q_est = R_W'(r_qm >> 32);
    assign qk    = q_est * r_k;
    assign rem   = r_x - R_W'(qk);
    assign q_fix = (rem >= R_W'(r_k)) ? q_est + R_W'(1) : q_est;

    assign rp = r_r * r_p;
    assign pp = r_p * r_p;

    assign val     = r_fin[2*P_W-1:38];
    assign val_big = |val[2*P_W-39:OUT_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load_tab && ({{(CMP_W-DIM_W){1'b0}}, i_dim_index} < CMP_W'(MAX_DIMS))) begin
            mem[IDX_W'(i_dim_index)] <= i_recip_width_in;
        end
        if (i_cmd_ctl.accept_elem) begin
            r_rd <= mem[r_count[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.accept_elem) begin
            r_ad    <= ad;
            r_valid <= i_elem_valid;
            r_last  <= i_last;
            r_gate  <= i_gating;
        end
        if (i_cmd_ctl.calc_sq) begin
            r_sq <= SQX_W'(r_ad * r_ad);
            r_w  <= i_cfg.ard ? r_rd : i_cfg.gwidth;
        end
        if (i_cmd_ctl.calc_wm) begin
            r_prod <= r_sq[LO_W-1:0] * r_w;
            r_big  <= (|r_sq[SQX_W-1:LO_W]) && (r_w != '0);
        end
        if (i_cmd_ctl.exp_init) begin
            r_r     <= r_sum[R_W+9:10];
            r_k     <= K_FIRST;
            r_sgp   <= i_cfg.scale * r_gate;
            r_sqcnt <= '0;
            r_p     <= o_status.exp_skip ? '0 : Q31_ONE;
        end
        if (i_cmd_ctl.exp_mul) begin
            r_x <= R_W'(rp >> 31);
        end
        if (i_cmd_ctl.exp_div) begin
            r_qm <= r_x * recip_of(r_k);
        end
        if (i_cmd_ctl.exp_cor) begin
            r_p <= Q31_ONE - P_W'(q_fix);
            r_k <= r_k - K_W'(1);
        end
        if (i_cmd_ctl.exp_sq) begin
            r_p     <= P_W'(pp >> 31);
            r_sqcnt <= r_sqcnt + K_W'(1);
        end
        if (i_cmd_ctl.exp_out) begin
            r_fin <= r_sgp * r_p;
        end
        if (i_cmd_ctl.finish) begin
            r_out_val <= val_big ? {OUT_W{1'b1}} : val[OUT_W-1:0];
            r_out_sat <= r_sat || val_big;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_count     <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd_ctl.accumulate && r_valid) begin
                if (use_w) begin
                    if (acc_sat) begin
                        r_sum <= SUM_MAX;
                        r_sat <= 1'b1;
                    end else begin
                        r_sum <= r_sum + SUM_W'(term);
                    end
                end
                if (r_count < CNT_W'(MAX_DIMS)) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd_ctl.finish) begin
                r_sum       <= '0;
                r_count     <= '0;
                r_sat       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.in_is_elem = i_cmd;
        o_status.last       = r_last;
        o_status.exp_skip   = (r_gate == '0) || (|r_sum[SUM_W-1:38]);
        o_status.k_last     = (r_k == K_W'(1));
        o_status.sq_last    = (r_sqcnt == {K_W{1'b1}});
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid    = r_out_valid;
    assign o_kernel_value = r_out_val;
    assign o_saturated    = r_out_sat;

endmodule

FILE: hw/rtl/ard_gaussian_kernel_eval_core.sv
// A table load leaves the block idle; the next transaction may follow at once.
// An element passes the square, width-multiply and accumulate steps before the next is taken.
// A last element adds the exponential of six series steps and eight squarings before the
// result is valid and the next transaction is taken; the exponential is skipped when the
// gating term is zero or the sum is too large; a stalled result holds the block.
// Reset is synchronous, active low, clears the accumulator and flags, and restores the registers.
module ard_gaussian_kernel_eval_core
    import agke_pkg::*;
#(
    parameter int unsigned MAX_DIMS     = 64,
    parameter int unsigned FEATURE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_cmd,
    input  logic [DIM_W-1:0]        i_dim_index,
    input  logic [RW_W-1:0]         i_recip_width_in,
    input  logic [FEATURE_BITS-1:0] i_feature_a,
    input  logic [FEATURE_BITS-1:0] i_feature_b,
    input  logic                    i_elem_valid,
    input  logic                    i_last,
    input  logic [GATE_W-1:0]       i_gating,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [OUT_W-1:0]        o_kernel_value,
    output logic                    o_saturated
);

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;
    logic    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale  <= 16'd256;
            r_cfg.gwidth <= 16'd4096;
            r_cfg.ard    <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_SCALE: r_cfg.scale  <= pwdata[SCALE_W-1:0];
                REG_GWID:  r_cfg.gwidth <= pwdata[RW_W-1:0];
                REG_ARD:   r_cfg.ard    <= pwdata[0];
                default:   r_cfg        <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SCALE: prdata = {16'd0, r_cfg.scale};
            REG_GWID:  prdata = {16'd0, r_cfg.gwidth};
            REG_ARD:   prdata = {31'd0, r_cfg.ard};
            default:   prdata = '0;
        endcase
    end

    agke_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    agke_datapath #(
        .MAX_DIMS     (MAX_DIMS),
        .FEATURE_BITS (FEATURE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd_ctl        (cmd),
        .o_status         (status),
        .i_cmd            (i_cmd),
        .i_dim_index      (i_dim_index),
        .i_recip_width_in (i_recip_width_in),
        .i_feature_a      (i_feature_a),
        .i_feature_b      (i_feature_b),
        .i_elem_valid     (i_elem_valid),
        .i_last           (i_last),
        .i_gating         (i_gating),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_kernel_value   (o_kernel_value),
        .o_saturated      (o_saturated)
    );

endmodule

FILE: hw/rtl/agke_checker.sv
module agke_checker
    import agke_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             i_cmd,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [OUT_W-1:0] o_kernel_value,
    input logic             o_saturated
);

    a_reset_idle: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> (!o_in_stall && !o_out_valid))
        else $error("Block not idle after reset.");

    a_elem_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_cmd) |=> o_in_stall)
        else $error("Element transaction did not occupy the block.");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_cmd) |=> !o_in_stall)
        else $error("Table load transaction stalled the input.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_kernel_value) && $stable(o_saturated)))
        else $error("Stalled result changed.");

endmodule

bind ard_gaussian_kernel_eval_core agke_checker u_agke_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_cmd          (i_cmd),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_kernel_value (o_kernel_value),
    .o_saturated    (o_saturated)
);

FILE: verif/ard_gaussian_kernel_eval_core_tb.sv
module ard_gaussian_kernel_eval_core_tb;
    import agke_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam bit CMD_LOAD = 1'b0;
    localparam bit CMD_ELEM = 1'b1;
    localparam int unsigned DIMS = 64;
    localparam longint unsigned SUM_TOP = (64'd1 << 40) - 64'd1;
    localparam longint unsigned OUT_TOP = (64'd1 << 24) - 64'd1;
    localparam longint unsigned ONE_Q31 = 64'd1 << 31;
    localparam int unsigned STALL_LIMIT = 20000;

    typedef struct {
        bit         cmd;
        bit [5:0]   dim;
        bit [15:0]  rw;
        bit [15:0]  fa;
        bit [15:0]  fb;
        bit         ev;
        bit         lst;
        bit [15:0]  gate;
        bit         typed;
        bit [23:0]  kv;
        bit         sat;
    } t_row;

    typedef struct {
        bit [23:0] kv;
        bit        sat;
    } t_kernel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [3:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_cmd = 1'b0;
    logic [DIM_W-1:0]      i_dim_index = '0;
    logic [RW_W-1:0]       i_recip_width_in = '0;
    logic [15:0]           i_feature_a = '0;
    logic [15:0]           i_feature_b = '0;
    logic                  i_elem_valid = 1'b0;
    logic                  i_last = 1'b0;
    logic [GATE_W-1:0]     i_gating = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [OUT_W-1:0]      o_kernel_value;
    logic                  o_saturated;

    ard_gaussian_kernel_eval_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_cmd(i_cmd), .i_dim_index(i_dim_index), .i_recip_width_in(i_recip_width_in),
        .i_feature_a(i_feature_a), .i_feature_b(i_feature_b),
        .i_elem_valid(i_elem_valid), .i_last(i_last), .i_gating(i_gating),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_kernel_value(o_kernel_value), .o_saturated(o_saturated)
    );

    always #5 i_clk = ~i_clk;

    bit [15:0]        amp_q88;
    bit [15:0]        global_width;
    bit               ard_on;
    bit [15:0]        width_table [DIMS];
    longint unsigned  dist_acc;
    int unsigned      elem_seen;
    bit               sat_flag;
    t_kernel          pending_kernels [$];
    int unsigned      errors = 0;
    bit               calm = 1'b0;
    int unsigned      quiet_cycles = 0;

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 21);
    endfunction

    function automatic longint unsigned decay_q31(longint unsigned s);
        longint unsigned r;
        longint unsigned p;
        if ((s >> 38) != 0) begin
            return 0;
        end
        r = s >> 10;
        p = ONE_Q31;
        for (int k = 6; k >= 1; k--) begin
            p = ONE_Q31 - (((r * p) >> 31) / longint'(k));
        end
        for (int k = 0; k < 8; k++) begin
            p = (p * p) >> 31;
        end
        return p;
    endfunction

    task automatic kernel_step(input t_row it, output bit has, output t_kernel res);
        longint unsigned w;
        longint unsigned ad;
        longint unsigned term;
        longint unsigned val;
        int d;
        bit apply;
        has = 1'b0;
        res = '{kv: '0, sat: 1'b0};
        if (it.cmd == CMD_LOAD) begin
            width_table[it.dim] = it.rw;
            return;
        end
        if (it.ev) begin
            apply = 1'b1;
            w = 64'(global_width);
            if (ard_on) begin
                if (elem_seen < DIMS) begin
                    w = 64'(width_table[elem_seen]);
                end else begin
                    apply = 1'b0;
                end
            end
            if (apply) begin
                d = int'($signed(it.fa)) - int'($signed(it.fb));
                ad = (d < 0) ? longint'(-d) : longint'(d);
                term = (ad * ad * w) >> 4;
                if (term > SUM_TOP - dist_acc) begin
                    dist_acc = SUM_TOP;
                    sat_flag = 1'b1;
                end else begin
                    dist_acc += term;
                end
            end
            if (elem_seen < DIMS) begin
                elem_seen++;
            end
        end
        if (!it.lst) begin
            return;
        end
        val = 0;
        if (it.gate != 0) begin
            val = (longint'(amp_q88) * longint'(it.gate) * decay_q31(dist_acc)) >> 38;
            if (val > OUT_TOP) begin
                val = OUT_TOP;
                sat_flag = 1'b1;
            end
        end
        has = 1'b1;
        res.kv = val[23:0];
        res.sat = sat_flag;
        dist_acc = 0;
        elem_seen = 0;
        sat_flag = 1'b0;
    endtask

    task automatic report(input string what, input longint unsigned got,
                          input longint unsigned want);
        $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_kernel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_kernels.size() == 0) begin
                report("unexpected transaction", 64'(o_kernel_value), 0);
            end else begin
                want = pending_kernels.pop_front();
                if (o_kernel_value !== want.kv) begin
                    report("kernel_value", 64'(o_kernel_value), 64'(want.kv));
                end
                if (o_saturated !== want.sat) begin
                    report("saturated", 64'(o_saturated), 64'(want.sat));
                end
            end
        end
        i_out_stall <= take_break();
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("ard_gaussian_kernel_eval_core_tb: errors");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input bit [15:0] sc, input bit [15:0] gw, input bit ae);
        reg_write(REG_SCALE, {16'd0, sc});
        reg_write(REG_GWID, {16'd0, gw});
        reg_write(REG_ARD, {31'd0, ae});
        amp_q88 = sc;
        global_width = gw;
        ard_on = ae;
    endtask

    task automatic send(input t_row it);
        bit has;
        t_kernel res;
        while (take_break()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cmd <= it.cmd;
        i_dim_index <= it.dim;
        i_recip_width_in <= it.rw;
        i_feature_a <= it.fa;
        i_feature_b <= it.fb;
        i_elem_valid <= it.ev;
        i_last <= it.lst;
        i_gating <= it.gate;
        i_in_valid <= 1'b1;
        kernel_step(it, has, res);
        if (has) begin
            pending_kernels.push_back(it.typed ? '{kv: it.kv, sat: it.sat} : res);
        end
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_kernels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (50) @(posedge i_clk);
    endtask

    function automatic t_row elem(bit [15:0] a, bit [15:0] b, bit ev, bit lst,
                                  bit [15:0] g);
        return '{cmd: CMD_ELEM, dim: 6'($urandom), rw: 16'($urandom), fa: a, fb: b, ev: ev,
                 lst: lst, gate: g, typed: 1'b0, kv: '0, sat: 1'b0};
    endfunction

    function automatic t_row random_elem(bit lst);
        bit [15:0] a;
        bit [15:0] b;
        bit [15:0] g;
        a = 16'($urandom);
        b = ($urandom_range(0, 3) == 0) ? 16'($urandom) : a + 16'($urandom_range(0, 512)) - 16'd256;
        case ($urandom_range(0, 7))
            0: g = 16'd0;
            1: g = 16'd32768;
            default: g = 16'($urandom_range(0, 32768));
        endcase
        return elem(a, b, $urandom_range(0, 9) != 0, lst, g);
    endfunction

    function automatic t_row table_load(bit [5:0] d, bit [15:0] w);
        return '{cmd: CMD_LOAD, dim: d, rw: w, fa: 16'($urandom), fb: 16'($urandom),
                 ev: 1'($urandom), lst: 1'($urandom), gate: 16'($urandom), typed: 1'b0,
                 kv: '0, sat: 1'b0};
    endfunction

    task automatic random_vectors(input int unsigned items);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < items) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 8);
            for (int unsigned i = 0; i <= len; i++) begin
                if ($urandom_range(0, 14) == 0) begin
                    send(table_load(6'($urandom), 16'($urandom)));
                    sent++;
                end
                send((i == len) ? random_elem(1'b1) : random_elem(1'b0));
                sent++;
            end
        end
    endtask

    initial begin
        t_row plan [12];
        plan[0]  = '{CMD_ELEM, 6'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h8000,
                     1'b1, 24'd65536, 1'b0};
        plan[1]  = '{CMD_ELEM, 6'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000,
                     1'b1, 24'd0, 1'b0};
        plan[2]  = '{CMD_LOAD, 6'd0,  16'hFFFF, 16'h1234, 16'h4321, 1'b1, 1'b1, 16'hFFFF,
                     1'b0, 24'd0, 1'b0};
        plan[3]  = '{CMD_LOAD, 6'd63, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
                     1'b0, 24'd0, 1'b0};
        plan[4]  = '{CMD_ELEM, 6'd0,  16'h0000, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 16'h8000,
                     1'b0, 24'd0, 1'b0};
        plan[5]  = '{CMD_ELEM, 6'd0,  16'h0000, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h8000,
                     1'b1, 24'd0, 1'b1};
        plan[6]  = '{CMD_ELEM, 6'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'h8000,
                     1'b1, 24'd65536, 1'b0};
        plan[7]  = '{CMD_ELEM, 6'd0,  16'h0000, 16'h03E8, 16'hFC18, 1'b1, 1'b1, 16'h4000,
                     1'b0, 24'd0, 1'b0};
        plan[8]  = '{CMD_ELEM, 6'd0,  16'h0000, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 16'h0000,
                     1'b0, 24'd0, 1'b0};
        plan[9]  = '{CMD_ELEM, 6'd0,  16'h0000, 16'h1234, 16'h4321, 1'b0, 1'b0, 16'h0000,
                     1'b0, 24'd0, 1'b0};
        plan[10] = '{CMD_ELEM, 6'd0,  16'h0000, 16'h0800, 16'hF800, 1'b1, 1'b1, 16'h0001,
                     1'b0, 24'd0, 1'b0};
        plan[11] = '{CMD_ELEM, 6'd0,  16'h0000, 16'h5555, 16'hAAAA, 1'b1, 1'b1, 16'h7FFF,
                     1'b0, 24'd0, 1'b0};

        amp_q88 = 16'd256;
        global_width = 16'd4096;
        ard_on = 1'b0;
        dist_acc = 0;
        elem_seen = 0;
        sat_flag = 1'b0;
        foreach (width_table[i]) begin
            width_table[i] = '0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            send(plan[i]);
        end
        drain();

        for (int unsigned d = 0; d < DIMS; d++) begin
            send(table_load(d[5:0], 16'($urandom_range(0, 1024))));
        end
        drain();

        set_config(16'hFFFF, 16'h0000, 1'b0);
        random_vectors(160);
        drain();

        set_config(16'h0000, 16'hFFFF, 1'b1);
        random_vectors(80);
        drain();

        calm = 1'b1;
        set_config(16'($urandom), 16'($urandom), 1'b1);
        random_vectors(250);
        drain();
        calm = 1'b0;

        set_config(16'($urandom_range(128, 2048)), 16'($urandom_range(1, 64)), 1'b0);
        random_vectors(250);
        drain();

        set_config(16'($urandom), 16'($urandom_range(0, 512)), 1'b1);
        random_vectors(200);
        drain();

        if (errors == 0) begin
            $display("ard_gaussian_kernel_eval_core_tb: clean");
        end else begin
            $display("ard_gaussian_kernel_eval_core_tb: errors");
        end
        $finish;
    end

endmodule
